// ===== hdl/ready_queue_scheduler_macros.svh =====
// Assertion macros used by the scheduler datapath.
`ifndef READY_QUEUE_SCHEDULER_MACROS_SVH
`define READY_QUEUE_SCHEDULER_MACROS_SVH

// Checked on every clock edge, reset included.
`define RQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

// Checked on every clock edge outside reset.
`define RQS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

// ===== hdl/rqs_pkg.sv =====
// ----------------------------------------------------------------------------
// rqs_pkg
// Types, codes and constants of the ready-queue scheduler.
// ----------------------------------------------------------------------------
package rqs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [1:0] POL_FCFS  = 2'd0;
  localparam logic [1:0] POL_SJF   = 2'd1;
  localparam logic [1:0] POL_RR    = 2'd2;
  localparam logic [1:0] POL_AGING = 2'd3;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic REG_POLICY  = 1'b0;
  localparam logic REG_QUANTUM = 1'b1;

  localparam logic [7:0] QUANTUM_RST = 8'd2;

  typedef struct packed {
    logic       command;
    logic [7:0] job_id;
    logic [9:0] job_length;
    logic [9:0] sort_key;
  } in_t;

  typedef struct packed {
    logic       ran_valid;
    logic [7:0] ran_job;
    logic       job_finished;
    logic       add_rejected;
    logic [4:0] jobs_waiting;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_RUN,
    ST_AGE,
    ST_MASK,
    ST_INSERT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic ld;
    logic pop;
    logic run;
    logic age;
    logic mask;
    logic ins;
    logic emit;
  } dp_cmd_t;

endpackage

// ===== hdl/rqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// rqs_ctrl
// Sequencer of the scheduler: steps one item through the datapath phases.
// ----------------------------------------------------------------------------
module rqs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_add,
  output logic             out_valid,
  input  logic             out_ready,
  output rqs_pkg::dp_cmd_t cmd
);
  import rqs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld    = 1'b1;
          state_nxt = (in_add == CMD_ADD) ? ST_MASK : ST_POP;
        end
      end
      ST_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        cmd.run   = 1'b1;
        state_nxt = ST_AGE;
      end
      ST_AGE: begin
        cmd.age   = 1'b1;
        state_nxt = ST_MASK;
      end
      ST_MASK: begin
        cmd.mask  = 1'b1;
        state_nxt = ST_INSERT;
      end
      ST_INSERT: begin
        cmd.ins   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // The result register is loaded only once the previous item is gone.
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/rqs_datapath.sv =====
// ----------------------------------------------------------------------------
// rqs_datapath
// Queue of waiting jobs, current job and result register.
// ----------------------------------------------------------------------------
`include "ready_queue_scheduler_macros.svh"

module rqs_datapath #(
  parameter int QUEUE_DEPTH = rqs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rqs_pkg::dp_cmd_t cmd,
  input  rqs_pkg::in_t     in_data,
  input  logic [1:0]       policy,
  input  logic [7:0]       quantum,
  output rqs_pkg::out_t    out_data
);
  import rqs_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]    q_id_r    [QUEUE_DEPTH];
  logic [9:0]    q_rem_r   [QUEUE_DEPTH];
  logic [9:0]    q_score_r [QUEUE_DEPTH];
  logic [CW-1:0] cnt_r;

  logic       cur_v_r;
  logic [7:0] cur_id_r;
  logic [9:0] cur_rem_r;
  logic [9:0] cur_score_r;
  logic [7:0] slice_r;

  logic       ins_pend_r, ins_sorted_r;
  logic [7:0] ins_id_r;
  logic [9:0] ins_rem_r, ins_score_r;
  logic       age_r;
  logic       ran_v_r, fin_r, rej_r;
  logic [7:0] ran_job_r;
  logic [QUEUE_DEPTH-1:0] mask_r;
  out_t       out_r;

  logic                   full;
  logic [QUEUE_DEPTH-1:0] shift_en, new_en;
  logic [7:0]             slice_inc, q_eff;
  logic [CW+4:0]          cnt_ext;

  assign full      = (cnt_r == CW'(QUEUE_DEPTH));
  assign slice_inc = (slice_r != 8'hFF) ? slice_r + 8'd1 : slice_r;
  assign q_eff     = (quantum == 8'd0) ? 8'd1 : quantum;
  assign cnt_ext   = {5'd0, cnt_r};

  // The new entry goes to the first slot that is not marked; later ones move up.
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      new_en[i]   = !seen && !mask_r[i];
      shift_en[i] = seen;
      seen        = seen || !mask_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      cur_v_r    <= 1'b0;
      slice_r    <= 8'd0;
      ins_pend_r <= 1'b0;
    end else begin
      if (cmd.ld) begin
        ins_pend_r   <= (in_data.command == CMD_ADD) && !full;
        ins_sorted_r <= (policy == POL_SJF) || (policy == POL_AGING);
        ins_id_r     <= in_data.job_id;
        ins_rem_r    <= in_data.job_length;
        ins_score_r  <= in_data.sort_key;
        rej_r        <= (in_data.command == CMD_ADD) && full;
        ran_v_r      <= 1'b0;
        ran_job_r    <= 8'd0;
        fin_r        <= 1'b0;
        age_r        <= 1'b0;
      end
      if (cmd.pop && !cur_v_r && cnt_r != '0) begin
        cur_v_r     <= 1'b1;
        cur_id_r    <= q_id_r[0];
        cur_rem_r   <= q_rem_r[0];
        cur_score_r <= q_score_r[0];
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          q_id_r[i]    <= q_id_r[i+1];
          q_rem_r[i]   <= q_rem_r[i+1];
          q_score_r[i] <= q_score_r[i+1];
        end
        cnt_r   <= cnt_r - CW'(1);
        slice_r <= 8'd0;
      end
      if (cmd.run && cur_v_r) begin
        ran_v_r   <= 1'b1;
        ran_job_r <= cur_id_r;
        ins_id_r    <= cur_id_r;
        ins_rem_r   <= cur_rem_r - 10'd1;
        ins_score_r <= cur_score_r;
        if (cur_rem_r <= 10'd1) begin
          fin_r     <= 1'b1;
          cur_v_r   <= 1'b0;
          cur_rem_r <= 10'd0;
          slice_r   <= 8'd0;
        end else begin
          cur_rem_r <= cur_rem_r - 10'd1;
          if (policy == POL_RR) begin
            if (slice_inc >= q_eff) begin
              slice_r <= 8'd0;
              if (!full) begin
                ins_pend_r   <= 1'b1;
                ins_sorted_r <= 1'b0;
                cur_v_r      <= 1'b0;
              end
            end else begin
              slice_r <= slice_inc;
            end
          end else if (policy == POL_AGING) begin
            age_r   <= 1'b1;
            slice_r <= 8'd0;
            if (!full) begin
              ins_pend_r   <= 1'b1;
              ins_sorted_r <= 1'b1;
              cur_v_r      <= 1'b0;
            end
          end
        end
      end
      if (cmd.age && age_r) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (q_score_r[i] != 10'd0) q_score_r[i] <= q_score_r[i] - 10'd1;
        end
      end
      if (cmd.mask) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          mask_r[i] <= (CW'(i) < cnt_r) && (!ins_sorted_r || q_score_r[i] < ins_score_r);
        end
      end
      if (cmd.ins && ins_pend_r) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (new_en[i]) begin
            q_id_r[i]    <= ins_id_r;
            q_rem_r[i]   <= ins_rem_r;
            q_score_r[i] <= ins_score_r;
          end else if (shift_en[i] && i > 0) begin
            q_id_r[i]    <= q_id_r[i-1];
            q_rem_r[i]   <= q_rem_r[i-1];
            q_score_r[i] <= q_score_r[i-1];
          end
        end
        cnt_r      <= cnt_r + CW'(1);
        ins_pend_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_r.ran_valid    <= ran_v_r;
        out_r.ran_job      <= ran_job_r;
        out_r.job_finished <= fin_r;
        out_r.add_rejected <= rej_r;
        out_r.jobs_waiting <= cnt_ext[4:0];
      end
    end
  end

  assign out_data = out_r;

  `RQS_ASSERT_RST(a_cnt_bound, cnt_r <= CW'(QUEUE_DEPTH), "queue count above depth")
  `RQS_ASSERT_RST(a_pop_loads, (cmd.pop && !cur_v_r && cnt_r != '0) |=> cur_v_r,
                  "pop did not load current job")
  `RQS_ASSERT_RST(a_ins_grows, (cmd.ins && ins_pend_r) |=> (cnt_r == $past(cnt_r) + CW'(1)),
                  "insert did not grow queue")
  `RQS_ASSERT_RST(a_rej_full, (cmd.ld && in_data.command == CMD_ADD && full) |=> !ins_pend_r,
                  "add to full queue was kept")

endmodule

// ===== hdl/ready_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// ready_queue_scheduler
// Phases: an add item runs load, mark, insert, emit; a step item runs load,
// pop, run, age, mark, insert, emit; emit may stall; one item at a time.
// Reset (synchronous, rst_n low): empty queue, no current job, FCFS, quantum 2.
// ----------------------------------------------------------------------------
module ready_queue_scheduler #(
  parameter int QUEUE_DEPTH = rqs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rqs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rqs_pkg::out_t out_data,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);
  import rqs_pkg::*;

  logic [1:0] policy_r;
  logic [7:0] quantum_r;
  dp_cmd_t    cmd;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r  <= POL_FCFS;
      quantum_r <= QUANTUM_RST;
    end else if (wr_en) begin
      if (cfg_paddr[2] == REG_POLICY) policy_r <= cfg_pwdata[1:0];
      else quantum_r <= cfg_pwdata[7:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_QUANTUM) ? {24'd0, quantum_r} : {30'd0, policy_r};

  rqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_add    (in_data.command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  rqs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .policy   (policy_r),
    .quantum  (quantum_r),
    .out_data (out_data)
  );

endmodule

// ===== tb/ready_queue_scheduler_checker.sv =====
// ----------------------------------------------------------------------------
// ready_queue_scheduler_checker
// Watches the item, result and register ports of the scheduler, keeps its own
// copy of the ready queue and the current job, predicts one result per
// accepted item and compares every accepted result against the oldest one.
// ----------------------------------------------------------------------------
module ready_queue_scheduler_checker
  import rqs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_t        out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          err_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] wait_id    [DEPTH];
  logic [9:0] wait_rem   [DEPTH];
  logic [9:0] wait_score [DEPTH];
  int         wait_cnt;

  logic       run_valid;
  logic [7:0] run_id;
  logic [9:0] run_rem;
  logic [9:0] run_score;
  logic [7:0] slice_cnt;

  logic [1:0] pol;
  logic [7:0] quantum;

  out_t expected_results[$];

  function automatic int score_slot(logic [9:0] score);
    int i;
    i = 0;
    while (i < wait_cnt && wait_score[i] < score) i++;
    return i;
  endfunction

  function automatic void queue_insert(int pos, logic [7:0] id, logic [9:0] rem,
                                       logic [9:0] score);
    for (int i = wait_cnt; i > pos; i--) begin
      wait_id[i]    = wait_id[i-1];
      wait_rem[i]   = wait_rem[i-1];
      wait_score[i] = wait_score[i-1];
    end
    wait_id[pos]    = id;
    wait_rem[pos]   = rem;
    wait_score[pos] = score;
    wait_cnt++;
  endfunction

  function automatic out_t schedule_item(in_t it);
    out_t r;
    int q;
    r = '0;
    if (it.command == CMD_ADD) begin
      if (wait_cnt >= DEPTH) begin
        r.add_rejected = 1'b1;
      end else if (pol == POL_SJF || pol == POL_AGING) begin
        queue_insert(score_slot(it.sort_key), it.job_id, it.job_length,
                     it.sort_key);
      end else begin
        queue_insert(wait_cnt, it.job_id, it.job_length, it.sort_key);
      end
    end else begin
      if (!run_valid && wait_cnt > 0) begin
        run_valid = 1'b1;
        run_id    = wait_id[0];
        run_rem   = wait_rem[0];
        run_score = wait_score[0];
        for (int i = 1; i < wait_cnt; i++) begin
          wait_id[i-1]    = wait_id[i];
          wait_rem[i-1]   = wait_rem[i];
          wait_score[i-1] = wait_score[i];
        end
        wait_cnt--;
        slice_cnt = '0;
      end
      if (run_valid) begin
        r.ran_valid = 1'b1;
        r.ran_job   = run_id;
        if (run_rem <= 1) begin
          run_rem        = '0;
          r.job_finished = 1'b1;
          run_valid      = 1'b0;
          slice_cnt      = '0;
        end else begin
          run_rem--;
          if (pol == POL_RR) begin
            q = (quantum == 0) ? 1 : quantum;
            if (slice_cnt != 8'hFF) slice_cnt++;
            if (slice_cnt >= q) begin
              slice_cnt = '0;
              if (wait_cnt < DEPTH) begin
                queue_insert(wait_cnt, run_id, run_rem, run_score);
                run_valid = 1'b0;
              end
            end
          end else if (pol == POL_AGING) begin
            for (int i = 0; i < wait_cnt; i++)
              if (wait_score[i] > 0) wait_score[i]--;
            slice_cnt = '0;
            if (wait_cnt < DEPTH) begin
              queue_insert(score_slot(run_score), run_id, run_rem, run_score);
              run_valid = 1'b0;
            end
          end
        end
      end
    end
    r.jobs_waiting = wait_cnt[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_t exp_r;
    if (!rst_n) begin
      wait_cnt  = 0;
      run_valid = 1'b0;
      run_id    = '0;
      run_rem   = '0;
      run_score = '0;
      slice_cnt = '0;
      pol       = POL_FCFS;
      quantum   = QUANTUM_RST;
      expected_results.delete();
      err_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_POLICY) pol = cfg_pwdata[1:0];
        else quantum = cfg_pwdata[7:0];
      end
      if (in_valid && in_ready) expected_results.push_back(schedule_item(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding: %p", out_data);
          err_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data.ran_valid !== exp_r.ran_valid) begin
            $error("ran_valid: expected %0d, got %0d", exp_r.ran_valid, out_data.ran_valid);
            err_count++;
          end
          if (out_data.ran_job !== exp_r.ran_job) begin
            $error("ran_job: expected %0d, got %0d", exp_r.ran_job, out_data.ran_job);
            err_count++;
          end
          if (out_data.job_finished !== exp_r.job_finished) begin
            $error("job_finished: expected %0d, got %0d", exp_r.job_finished,
                   out_data.job_finished);
            err_count++;
          end
          if (out_data.add_rejected !== exp_r.add_rejected) begin
            $error("add_rejected: expected %0d, got %0d", exp_r.add_rejected,
                   out_data.add_rejected);
            err_count++;
          end
          if (out_data.jobs_waiting !== exp_r.jobs_waiting) begin
            $error("jobs_waiting: expected %0d, got %0d", exp_r.jobs_waiting,
                   out_data.jobs_waiting);
            err_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/tb_ready_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_ready_queue_scheduler
// Drives the scheduler with a short directed run and then randomized phases
// under every policy and a range of quanta, with bursty items, receiver
// stalls and one long back-pressure stretch; the checker judges the results.
// ----------------------------------------------------------------------------
module tb_ready_queue_scheduler;
  import rqs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          err_count;
  int          pending;

  int   burst_left;
  int   idle_cycles;
  logic hold_req;

  ready_queue_scheduler DUT (.*);

  ready_queue_scheduler_checker u_checker (.*);

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    hold_req    = 1'b0;
    burst_left  = 0;
    idle_cycles = 0;
  end

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_ready_queue_scheduler: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: segments of always-ready, random and mostly-stalled behavior,
  // plus one long hold-off on request.
  initial begin
    int seg;
    int mode;
    bit held;
    seg  = 0;
    mode = 0;
    held = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if (seg == 0) begin
        seg  = $urandom_range(5, 60);
        mode = $urandom_range(0, 2);
      end
      seg--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 5) == 0);
      endcase
      @(posedge clk);
    end
  end

  task automatic send_item(in_t d);
    in_data  <= d;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // A step item runs through every sequencer phase; leave margin before touching registers.
    repeat (12) @(posedge clk);
  endtask

  task automatic reg_write(logic reg_sel, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_t job_item(logic cmd, int len);
    in_t d;
    d.command    = cmd;
    d.job_id     = 8'($urandom_range(0, 255));
    d.job_length = 10'(len);
    d.sort_key   = 10'($urandom_range(0, 1023));
    return d;
  endfunction

  function automatic in_t random_item(int step_pct);
    int sel;
    int len;
    sel = $urandom_range(0, 99);
    if (sel < 70) len = $urandom_range(1, 6);
    else if (sel < 80) len = 0;
    else if (sel < 95) len = $urandom_range(7, 40);
    else len = $urandom_range(0, 1023);
    return job_item(($urandom_range(0, 99) < step_pct) ? CMD_STEP : CMD_ADD, len);
  endfunction

  initial begin
    logic [1:0] pol_list [9];
    logic [7:0] q_list   [9];
    in_t d;
    int step_pct;
    pol_list = '{POL_RR, POL_FCFS, POL_SJF, POL_RR, POL_AGING, POL_RR, POL_RR,
                 POL_AGING, POL_SJF};
    q_list   = '{8'd2, 8'd1, 8'd30, 8'd30, 8'd2, 8'd255, 8'd0, 8'd1, 8'd2};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle step, zero-length job, extreme fields, full queue.
    send_item(job_item(CMD_STEP, 1));
    d = '{CMD_ADD, 8'd0, 10'd0, 10'd0};
    send_item(d);
    send_item(job_item(CMD_STEP, 1));
    d = '{CMD_ADD, 8'd255, 10'd1023, 10'd1023};
    send_item(d);
    for (int i = 0; i < 16; i++) send_item(job_item(CMD_ADD, 1));
    send_item(job_item(CMD_STEP, 1));
    drain();

    for (int p = 0; p < 9; p++) begin
      reg_write(REG_POLICY, {30'd0, pol_list[p]});
      reg_write(REG_QUANTUM, {24'd0, q_list[p]});
      step_pct = 30 + 10 * (p % 5);
      for (int n = 0; n < 155; n++) begin
        if (p == 2 && n == 40) hold_req <= 1'b1;
        if (p == 4 && n == 80) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_item(random_item(step_pct));
      end
      drain();
    end

    if (err_count == 0 && pending == 0) begin
      $display("tb_ready_queue_scheduler: done, clean");
    end else begin
      $display("tb_ready_queue_scheduler: done, errors");
    end
    $finish;
  end

endmodule

// ===== ready_queue_scheduler.f =====
+incdir+hdl
hdl/rqs_pkg.sv
hdl/rqs_ctrl.sv
hdl/rqs_datapath.sv
hdl/ready_queue_scheduler.sv
tb/ready_queue_scheduler_checker.sv
tb/tb_ready_queue_scheduler.sv
